/* hdl/u2u_pkg.sv */
package u2u_pkg;

  // surrogate ranges
  localparam logic [15:0] SurrFirst = 16'hD800;
  localparam logic [15:0] HighLast  = 16'hDBFF;
  localparam logic [15:0] LowFirst  = 16'hDC00;
  localparam logic [15:0] SurrLast  = 16'hDFFF;

  localparam int unsigned ScalarW = 21;
  localparam logic [ScalarW-1:0] SuppBase = 21'h10000;

  // utf-8 limits and byte marks
  localparam logic [ScalarW-1:0] Utf8Lim1 = 21'h00080;
  localparam logic [ScalarW-1:0] Utf8Lim2 = 21'h00800;
  localparam logic [7:0] Utf8Cont  = 8'h80;
  localparam logic [7:0] Utf8Lead2 = 8'hC0;
  localparam logic [7:0] Utf8Lead3 = 8'hE0;
  localparam logic [7:0] Utf8Lead4 = 8'hF0;

  // configuration register indexes
  localparam logic [0:0] CfgOutputFormat = 1'b0;
  localparam logic [0:0] CfgPairOrder    = 1'b1;

  // one unit of work handed from the front to the back
  typedef struct packed {
    logic               err;
    logic               pair;
    logic               fmt;
    logic               rev;
    logic [ScalarW-1:0] scalar;
  } job_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [31:0] byte_rev(input logic [31:0] w);
    byte_rev = {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

/* hdl/u2u_front.sv */
module u2u_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [0:0]     cfg_idx_i,
  input  logic           cfg_data_i,
  input  logic           accept_i,
  input  logic [15:0]    code_unit_i,
  input  logic           final_unit_i,
  output logic           job_push_o,
  output u2u_pkg::job_t  job_o
);
  import u2u_pkg::*;

  logic        fmt_q, order_q;
  logic        held_q, held_d;
  logic [15:0] held_unit_q;
  logic        err_q, err_d;

  logic        is_surr, is_high, is_low, lead, trail;
  logic        produce;
  logic [9:0]  hi_bits, lo_bits;
  job_t        job;

  always_comb begin
    is_surr = (code_unit_i >= SurrFirst) && (code_unit_i <= SurrLast);
    is_high = (code_unit_i >= SurrFirst) && (code_unit_i <= HighLast);
    is_low  = (code_unit_i >= LowFirst) && (code_unit_i <= SurrLast);
    lead    = order_q ? is_low : is_high;
    trail   = order_q ? is_high : is_low;
    hi_bits = order_q ? code_unit_i[9:0] : held_unit_q[9:0];
    lo_bits = order_q ? held_unit_q[9:0] : code_unit_i[9:0];

    job.err    = 1'b0;
    job.pair   = 1'b0;
    job.fmt    = fmt_q;
    job.rev    = order_q;
    job.scalar = {5'd0, code_unit_i};
    produce    = 1'b0;
    held_d     = held_q;
    err_d      = err_q;

    if (!err_q) begin
      if (held_q) begin
        produce = 1'b1;
        held_d  = 1'b0;
        if (!trail) begin
          job.err = 1'b1;
          err_d   = 1'b1;
        end else begin
          job.pair   = 1'b1;
          job.scalar = {1'b0, hi_bits, lo_bits} + SuppBase;
        end
      end else if (!is_surr) begin
        produce = 1'b1;
      end else if (lead && !final_unit_i) begin
        held_d = 1'b1;
      end else begin
        produce = 1'b1;
        job.err = 1'b1;
        err_d   = 1'b1;
      end
    end
  end

  assign job_push_o = accept_i && produce;
  assign job_o      = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= 1'b0;
      order_q <= 1'b0;
      held_q  <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgOutputFormat) fmt_q <= cfg_data_i;
        if (cfg_idx_i == CfgPairOrder) order_q <= cfg_data_i;
      end
      if (accept_i) begin
        held_q <= held_d;
        err_q  <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && !err_q && !held_q && lead && !final_unit_i) begin
      held_unit_q <= code_unit_i;
    end
  end

  // once the sticky error is set nothing more reaches the back
  a_silent_after_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> !job_push_o) else $error("job issued after sticky error");

endmodule

/* hdl/u2u_fifo.sv */
module u2u_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  u2u_pkg::job_t    data_i,
  input  logic             pop_i,
  output u2u_pkg::job_t    data_o,
  output u2u_pkg::q_stat_t stat_o
);
  import u2u_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == FullCnt);
  assign stat_o.empty = (cnt_q == '0);
  assign data_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue fill count out of step");

endmodule

/* hdl/u2u_back.sv */
module u2u_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  u2u_pkg::job_t    job_i,
  input  u2u_pkg::q_stat_t q_stat_i,
  output logic             q_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [31:0]      out_value_o,
  output logic             last_of_run_o,
  output logic             error_flag_o
);
  import u2u_pkg::*;

  logic        out_valid_q;
  logic [31:0] value_q;
  logic        last_q, err_q;
  logic [1:0]  idx_q;

  logic        head_valid, out_ready, advance, is_last;
  logic [1:0]  last_idx, rem;
  logic [5:0]  six;
  logic [7:0]  utf8_byte;
  logic [31:0] word, value_d;

  always_comb begin
    head_valid = !q_stat_i.empty;
    out_ready  = !out_valid_q || pop_i;
    advance    = head_valid && out_ready;

    if (job_i.err || job_i.fmt) begin
      last_idx = 2'd0;
    end else if (job_i.pair) begin
      last_idx = 2'd3;
    end else if (job_i.scalar < Utf8Lim1) begin
      last_idx = 2'd0;
    end else if (job_i.scalar < Utf8Lim2) begin
      last_idx = 2'd1;
    end else begin
      last_idx = 2'd2;
    end
    is_last = (idx_q == last_idx);

    rem = last_idx - idx_q;
    case (rem)
      2'd0:    six = job_i.scalar[5:0];
      2'd1:    six = job_i.scalar[11:6];
      default: six = job_i.scalar[17:12];
    endcase

    if (idx_q == 2'd0) begin
      case (last_idx)
        2'd0:    utf8_byte = {1'b0, job_i.scalar[6:0]};
        2'd1:    utf8_byte = Utf8Lead2 | {3'd0, job_i.scalar[10:6]};
        2'd2:    utf8_byte = Utf8Lead3 | {4'd0, job_i.scalar[15:12]};
        default: utf8_byte = Utf8Lead4 | {5'd0, job_i.scalar[20:18]};
      endcase
    end else begin
      utf8_byte = Utf8Cont | {2'd0, six};
    end

    word = {11'd0, job_i.scalar};
    if (job_i.err) begin
      value_d = '0;
    end else if (job_i.fmt) begin
      value_d = (job_i.pair && job_i.rev) ? byte_rev(word) : word;
    end else begin
      value_d = {24'd0, utf8_byte};
    end
  end

  assign q_pop_o       = advance && is_last;
  assign empty_o       = !out_valid_q;
  assign out_value_o   = value_q;
  assign last_of_run_o = last_q;
  assign error_flag_o  = err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        idx_q       <= is_last ? 2'd0 : idx_q + 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      value_q <= value_d;
      last_q  <= is_last;
      err_q   <= job_i.err;
    end
  end

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && err_q |-> last_q && value_q == '0)
    else $error("error result not single and zero");

  a_multi_utf8: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid && idx_q != 2'd0 |-> !job_i.err && !job_i.fmt)
    else $error("byte index advanced on a single-result job");

endmodule

/* hdl/utf16_to_utf8_utf32_converter_top.sv */
// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+-------------------------------------------
// input     | in        | push / full           | code_unit_i[15:0], final_unit_i
// result    | out       | empty / pop           | out_value_o[31:0], last_of_run_o, error_flag_o
// config    | in        | cfg_we_i (no wait)    | cfg_idx_i, cfg_data_i
//
// a code unit is decoded in the cycle it is taken; its work lands in a small job queue
// the back stage drains one job as one to four results, one result per cycle unless pop is held
// low: four for a supplementary pair in utf-8, so the 32-bit output register sets the pace
// input keeps flowing while results wait, until the job queue fills (full)
// reset clears the held surrogate, the sticky error, both registers and the job queue
module utf16_to_utf8_utf32_converter_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic        cfg_data_i,
  // input transactions
  input  logic        push,
  output logic        full,
  input  logic [15:0] code_unit_i,
  input  logic        final_unit_i,
  // result transactions
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_value_o,
  output logic        last_of_run_o,
  output logic        error_flag_o
);
  import u2u_pkg::*;

  logic    accept;
  logic    job_push, job_pop;
  job_t    job_in, job_head;
  q_stat_t q_stat;

  // an input transaction is taken whenever the job queue has room
  assign full   = q_stat.full;
  assign accept = push && !q_stat.full;

  // front: surrogate pairing, sticky error, register file
  u2u_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (accept),
    .code_unit_i  (code_unit_i),
    .final_unit_i (final_unit_i),
    .job_push_o   (job_push),
    .job_o        (job_in)
  );

  // decouples decode from byte emission
  u2u_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_in),
    .pop_i  (job_pop),
    .data_o (job_head),
    .stat_o (q_stat)
  );

  // back: expands a job into its result transactions via a registered output
  u2u_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (job_head),
    .q_stat_i      (q_stat),
    .q_pop_o       (job_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .out_value_o   (out_value_o),
    .last_of_run_o (last_of_run_o),
    .error_flag_o  (error_flag_o)
  );

endmodule

/* tb/tb_top.sv */
// checks the utf-16 transcoder against a cycle-free predictor of its own
// directed table first, then random well-formed strings over all four register settings,
// then the error rows and a noisy tail, since the sticky error only clears on reset
module tb_top;

  typedef struct packed {
    logic [31:0] value;
    logic        is_last;
    logic        is_err;
  } result_t;

  typedef enum logic {
    RowUnit,
    RowMode
  } row_kind_e;

  // want holds typed results: the whole word when n is 1, else n bytes msb first
  typedef struct packed {
    row_kind_e   kind;
    logic [15:0] cu;
    logic        fin;
    logic        fmt;
    logic        ord;
    int          n;
    logic        err;
    logic [31:0] want;
  } row_t;

  localparam int Predict     = -1;
  localparam int NumRows     = 41;
  localparam int ErrFirst    = 33;
  localparam int NumPhases   = 8;
  localparam int PhaseUnits  = 45;
  localparam int NoiseUnits  = 20;
  localparam int DrainCycles = 16;
  localparam int StallLimit  = 4000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic        cfg_data_i;
  logic        push;
  logic        full;
  logic [15:0] code_unit_i;
  logic        final_unit_i;
  logic        empty;
  logic        pop;
  logic [31:0] out_value_o;
  logic        last_of_run_o;
  logic        error_flag_o;

  utf16_to_utf8_utf32_converter_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .push         (push),
    .full         (full),
    .code_unit_i  (code_unit_i),
    .final_unit_i (final_unit_i),
    .empty        (empty),
    .pop          (pop),
    .out_value_o  (out_value_o),
    .last_of_run_o(last_of_run_o),
    .error_flag_o (error_flag_o)
  );

  // directed stimulus, state after reset is utf-8 with the high surrogate leading
  row_t rows [NumRows] = '{
    '{RowUnit, 16'h0000, 1'b0, 1'b0, 1'b0, 1,       1'b0, 32'h0000_0000},
    '{RowUnit, 16'h007F, 1'b1, 1'b0, 1'b0, 1,       1'b0, 32'h0000_007F},
    '{RowUnit, 16'h0080, 1'b0, 1'b0, 1'b0, 2,       1'b0, 32'h0000_C280},
    '{RowUnit, 16'h07FF, 1'b0, 1'b0, 1'b0, 2,       1'b0, 32'h0000_DFBF},
    '{RowUnit, 16'h0800, 1'b1, 1'b0, 1'b0, 3,       1'b0, 32'h00E0_A080},
    '{RowUnit, 16'hFFFF, 1'b0, 1'b0, 1'b0, 3,       1'b0, 32'h00EF_BFBF},
    '{RowUnit, 16'hD7FF, 1'b0, 1'b0, 1'b0, Predict, 1'b0, 32'h0},
    '{RowUnit, 16'hE000, 1'b1, 1'b0, 1'b0, Predict, 1'b0, 32'h0},
    // lowest and highest supplementary scalars
    '{RowUnit, 16'hD800, 1'b0, 1'b0, 1'b0, 0,       1'b0, 32'h0},
    '{RowUnit, 16'hDC00, 1'b1, 1'b0, 1'b0, 4,       1'b0, 32'hF090_8080},
    '{RowUnit, 16'hDBFF, 1'b0, 1'b0, 1'b0, 0,       1'b0, 32'h0},
    '{RowUnit, 16'hDFFF, 1'b0, 1'b0, 1'b0, 4,       1'b0, 32'hF48F_BFBF},
    '{RowUnit, 16'hD8A5, 1'b0, 1'b0, 1'b0, Predict, 1'b0, 32'h0},
    '{RowUnit, 16'hDE17, 1'b1, 1'b0, 1'b0, Predict, 1'b0, 32'h0},
    // utf-32 words
    '{RowMode, 16'h0000, 1'b0, 1'b1, 1'b0, 0,       1'b0, 32'h0},
    '{RowUnit, 16'h0000, 1'b0, 1'b0, 1'b0, 1,       1'b0, 32'h0000_0000},
    '{RowUnit, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1,       1'b0, 32'h0000_FFFF},
    '{RowUnit, 16'hD800, 1'b0, 1'b0, 1'b0, 0,       1'b0, 32'h0},
    '{RowUnit, 16'hDC00, 1'b0, 1'b0, 1'b0, 1,       1'b0, 32'h0001_0000},
    // swapped order, pair words come out byte-reversed
    '{RowMode, 16'h0000, 1'b0, 1'b1, 1'b1, 0,       1'b0, 32'h0},
    '{RowUnit, 16'hDFFF, 1'b0, 1'b0, 1'b0, 0,       1'b0, 32'h0},
    '{RowUnit, 16'hDBFF, 1'b1, 1'b0, 1'b0, 1,       1'b0, 32'hFFFF_1000},
    '{RowUnit, 16'hDC00, 1'b0, 1'b0, 1'b0, 0,       1'b0, 32'h0},
    '{RowUnit, 16'hD800, 1'b0, 1'b0, 1'b0, 1,       1'b0, 32'h0000_0100},
    '{RowMode, 16'h0000, 1'b0, 1'b0, 1'b1, 0,       1'b0, 32'h0},
    '{RowUnit, 16'hDC12, 1'b0, 1'b0, 1'b0, Predict, 1'b0, 32'h0},
    '{RowUnit, 16'hD834, 1'b0, 1'b0, 1'b0, Predict, 1'b0, 32'h0},
    // order flipped while a surrogate is held, both ways round
    '{RowUnit, 16'hDC00, 1'b0, 1'b0, 1'b0, 0,       1'b0, 32'h0},
    '{RowMode, 16'h0000, 1'b0, 1'b0, 1'b0, 0,       1'b0, 32'h0},
    '{RowUnit, 16'hDC05, 1'b1, 1'b0, 1'b0, Predict, 1'b0, 32'h0},
    '{RowUnit, 16'hD800, 1'b0, 1'b0, 1'b0, 0,       1'b0, 32'h0},
    '{RowMode, 16'h0000, 1'b0, 1'b1, 1'b1, 0,       1'b0, 32'h0},
    '{RowUnit, 16'hDBFF, 1'b0, 1'b0, 1'b0, Predict, 1'b0, 32'h0},
    // error rows: a mismatched pair latches the error, the rest must stay silent
    '{RowMode, 16'h0000, 1'b0, 1'b0, 1'b0, 0,       1'b0, 32'h0},
    '{RowUnit, 16'hD800, 1'b0, 1'b0, 1'b0, 0,       1'b0, 32'h0},
    '{RowUnit, 16'h0041, 1'b0, 1'b0, 1'b0, 1,       1'b1, 32'h0},
    // leading surrogate on the final unit
    '{RowUnit, 16'hDBFF, 1'b1, 1'b0, 1'b0, 0,       1'b0, 32'h0},
    // lone trailing surrogate
    '{RowUnit, 16'hDC00, 1'b0, 1'b0, 1'b0, 0,       1'b0, 32'h0},
    // unfinished pair
    '{RowUnit, 16'hD800, 1'b0, 1'b0, 1'b0, 0,       1'b0, 32'h0},
    '{RowUnit, 16'hD801, 1'b1, 1'b0, 1'b0, 0,       1'b0, 32'h0},
    '{RowUnit, 16'h0041, 1'b0, 1'b0, 1'b0, 0,       1'b0, 32'h0}
  };

  // predictor state and the results it expects, oldest first
  logic        fmt_q;
  logic        ord_q;
  logic [15:0] held_q;
  logic        held_v_q;
  logic        err_q;
  result_t     staged [4];
  int          staged_n;
  result_t     results_due [$];
  int          mismatches;
  int          quiet_cycles;
  logic [8:0]  stall_phase;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void stage(input logic [31:0] v, input logic last_b, input logic err_b);
    staged[staged_n] = '{value: v, is_last: last_b, is_err: err_b};
    staged_n++;
  endfunction

  function automatic void stage_error();
    err_q    = 1'b1;
    held_v_q = 1'b0;
    stage(32'h0, 1'b1, 1'b1);
  endfunction

  // works out the results of one code unit and moves the predictor state on
  function automatic void transcode(input logic [15:0] cu, input logic fin);
    logic        is_hi;
    logic        is_lo;
    logic        leads;
    logic        trails;
    logic [15:0] hi_u;
    logic [15:0] lo_u;
    logic [20:0] scalar;
    logic [31:0] word;
    is_hi    = cu[15:10] == 6'b110110;
    is_lo    = cu[15:10] == 6'b110111;
    leads    = ord_q ? is_lo : is_hi;
    trails   = ord_q ? is_hi : is_lo;
    staged_n = 0;
    if (err_q) return;
    if (held_v_q) begin
      if (!trails) begin
        stage_error();
        return;
      end
      // the held unit counts as the leading one of the order in force now
      hi_u     = ord_q ? cu : held_q;
      lo_u     = ord_q ? held_q : cu;
      held_v_q = 1'b0;
      held_q   = 16'h0;
      scalar   = {1'b0, hi_u[9:0], lo_u[9:0]} + 21'h10000;
      word     = {11'b0, scalar};
      if (fmt_q) begin
        stage(ord_q ? {word[7:0], word[15:8], word[23:16], word[31:24]} : word, 1'b1, 1'b0);
      end else begin
        stage({24'b0, 5'b11110, scalar[20:18]}, 1'b0, 1'b0);
        stage({24'b0, 2'b10, scalar[17:12]}, 1'b0, 1'b0);
        stage({24'b0, 2'b10, scalar[11:6]}, 1'b0, 1'b0);
        stage({24'b0, 2'b10, scalar[5:0]}, 1'b1, 1'b0);
      end
      return;
    end
    if (cu[15:11] != 5'b11011) begin
      if (fmt_q || cu < 16'h0080) begin
        stage({16'b0, cu}, 1'b1, 1'b0);
      end else if (cu < 16'h0800) begin
        stage({24'b0, 3'b110, cu[10:6]}, 1'b0, 1'b0);
        stage({24'b0, 2'b10, cu[5:0]}, 1'b1, 1'b0);
      end else begin
        stage({24'b0, 4'b1110, cu[15:12]}, 1'b0, 1'b0);
        stage({24'b0, 2'b10, cu[11:6]}, 1'b0, 1'b0);
        stage({24'b0, 2'b10, cu[5:0]}, 1'b1, 1'b0);
      end
      return;
    end
    if (leads && !fin) begin
      held_q   = cu;
      held_v_q = 1'b1;
      return;
    end
    stage_error();
  endfunction

  function automatic void queue_predicted();
    for (int k = 0; k < staged_n; k++) results_due.push_back(staged[k]);
  endfunction

  function automatic void queue_typed(input row_t r);
    logic [31:0] v;
    if (r.err) begin
      results_due.push_back('{value: 32'h0, is_last: 1'b1, is_err: 1'b1});
      return;
    end
    for (int k = 0; k < r.n; k++) begin
      v = (r.n == 1) ? r.want : {24'b0, r.want[8*(r.n-1-k) +: 8]};
      results_due.push_back('{value: v, is_last: k == r.n - 1, is_err: 1'b0});
    end
  endfunction

  function automatic logic [15:0] random_bmp();
    logic [15:0] u;
    case ($urandom_range(0, 4))
      0: u = 16'($urandom_range(16'h0000, 16'h007F));
      1: u = 16'($urandom_range(16'h0080, 16'h07FF));
      2: u = 16'($urandom_range(16'h0800, 16'hD7FF));
      3: u = 16'($urandom_range(16'hE000, 16'hFFFF));
      default: begin
        // range boundaries
        case ($urandom_range(0, 7))
          0: u = 16'h0000;
          1: u = 16'h007F;
          2: u = 16'h0080;
          3: u = 16'h07FF;
          4: u = 16'h0800;
          5: u = 16'hD7FF;
          6: u = 16'hE000;
          default: u = 16'hFFFF;
        endcase
      end
    endcase
    return u;
  endfunction

  // one input transaction, predicted once it is taken
  task automatic send(input logic [15:0] cu, input logic fin);
    @(negedge clk_i);
    push         <= 1'b1;
    code_unit_i  <= cu;
    final_unit_i <= fin;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    transcode(cu, fin);
  endtask

  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
  endtask

  // stop sending and let every outstanding result drain, plus margin for
  // units that are held and so produce nothing yet
  task automatic settle();
    @(negedge clk_i);
    push <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic f, input logic o);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= u2u_pkg::CfgOutputFormat;
    cfg_data_i <= f;
    @(negedge clk_i);
    cfg_idx_i  <= u2u_pkg::CfgPairOrder;
    cfg_data_i <= o;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    fmt_q = f;
    ord_q = o;
  endtask

  task automatic run_rows(input int lo, input int hi);
    for (int i = lo; i < hi; i++) begin
      if (rows[i].kind == RowMode) begin
        settle();
        set_mode(rows[i].fmt, rows[i].ord);
      end else begin
        if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 3));
        send(rows[i].cu, rows[i].fin);
        if (rows[i].n == Predict) queue_predicted();
        else queue_typed(rows[i]);
      end
    end
  endtask

  // well-formed strings with random content, one register setting per phase
  task automatic run_phases();
    int          sent;
    int          burst;
    logic        quiet;
    logic        fin;
    logic [15:0] hi_u;
    logic [15:0] lo_u;
    burst = 0;
    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      // the first four phases walk every setting, the rest pick at random
      if (ph < 4) set_mode(ph[1], ph[0]);
      else set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      quiet = (ph % 3 == 1);
      sent  = 0;
      while (sent < PhaseUnits) begin
        if (!quiet && burst == 0) begin
          burst = $urandom_range(1, 12);
          hold_off($urandom_range(0, 7) == 0 ? $urandom_range(10, 25) : $urandom_range(0, 5));
        end
        if ($urandom_range(0, 59) == 0) settle();
        fin = $urandom_range(0, 3) == 0;
        if ($urandom_range(0, 9) < 6) begin
          send(random_bmp(), fin);
          queue_predicted();
          sent++;
        end else begin
          hi_u = 16'hD800 | 16'($urandom_range(0, 1023));
          lo_u = 16'hDC00 | 16'($urandom_range(0, 1023));
          send(ord_q ? lo_u : hi_u, 1'b0);
          queue_predicted();
          send(ord_q ? hi_u : lo_u, fin);
          queue_predicted();
          sent += 2;
        end
        if (burst > 0) burst--;
      end
    end
  endtask

  // receiver stalls on a pattern that moves through several moods
  always @(negedge clk_i) begin
    stall_phase <= stall_phase + 9'd1;
    case (stall_phase[8:6])
      3'd0, 3'd1: pop <= 1'b1;
      3'd2, 3'd3, 3'd4: pop <= 1'($urandom_range(0, 1));
      3'd5: pop <= stall_phase[1:0] == 2'd0;
      3'd6: pop <= stall_phase[5:0] >= 6'd40;
      default: pop <= $urandom_range(0, 3) != 0;
    endcase
  end

  // compare every result transaction with the oldest expectation
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && pop && !empty) begin
      if (results_due.size() == 0) begin
        $error("out_value: unexpected result %h", out_value_o);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (out_value_o !== want.value) begin
          $error("out_value: expected %h, got %h", want.value, out_value_o);
          mismatches++;
        end
        if (last_of_run_o !== want.is_last) begin
          $error("last_of_run: expected %b, got %b", want.is_last, last_of_run_o);
          mismatches++;
        end
        if (error_flag_o !== want.is_err) begin
          $error("error_flag: expected %b, got %b", want.is_err, error_flag_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= StallLimit);
    $display("utf16_to_utf8_utf32_converter_top: mismatch");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    push         = 1'b0;
    code_unit_i  = 16'h0;
    final_unit_i = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = u2u_pkg::CfgOutputFormat;
    cfg_data_i   = 1'b0;
    pop          = 1'b0;
    stall_phase  = 9'd0;
    quiet_cycles = 0;
    mismatches   = 0;
    fmt_q        = 1'b0;
    ord_q        = 1'b0;
    held_q       = 16'h0;
    held_v_q     = 1'b0;
    err_q        = 1'b0;
    staged_n     = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_rows(0, ErrFirst);
    run_phases();
    run_rows(ErrFirst, NumRows);

    // noise after the error has latched, surrogates weighted up
    for (int i = 0; i < NoiseUnits; i++) begin
      if ($urandom_range(0, 1) == 0) send(16'hD800 | 16'($urandom_range(0, 16'h07FF)), 1'($urandom));
      else send(16'($urandom_range(0, 16'hFFFF)), 1'($urandom));
      queue_predicted();
    end

    @(negedge clk_i);
    push <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (2 * DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("utf16_to_utf8_utf32_converter_top: match");
    end else begin
      $display("utf16_to_utf8_utf32_converter_top: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/u2u_pkg.sv
hdl/u2u_front.sv
hdl/u2u_fifo.sv
hdl/u2u_back.sv
hdl/utf16_to_utf8_utf32_converter_top.sv
tb/tb_top.sv
